// File: rtl/lmmt_pkg.sv
package lmmt_pkg;

  // Field widths fixed by the item formats.
  localparam int SLOT_W  = 3;
  localparam int TIME_W  = 20;
  localparam int COUNT_W = 32;

  // Number of statistics slots kept in the store.
  localparam int SLOTS      = 8;
  localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // One wrap of the microsecond counter.
  localparam logic [TIME_W-1:0] US_PER_WRAP = 20'd1000000;

  // Saturation value of the per-slot sample count.
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Input item as it arrives on the command port.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] start_us;
    logic [TIME_W-1:0] now_us;
  } lmmt_in_t;

  // Result item as delivered with the done strobe.
  typedef struct packed {
    logic [TIME_W-1:0]  elapsed_us;
    logic [TIME_W-1:0]  min_us;
    logic [TIME_W-1:0]  max_us;
    logic [TIME_W-1:0]  mean_us;
    logic [COUNT_W-1:0] sample_count;
  } lmmt_out_t;

  // What the back end has to do with a queued item.
  typedef enum logic {
    CMD_SKIP,
    CMD_UPDATE
  } lmmt_kind_e;

  // Classified item held in the queue.
  typedef struct packed {
    lmmt_kind_e        kind;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] elapsed_us;
  } lmmt_cmd_t;

  // Queue status seen by front and back.
  typedef struct packed {
    logic empty;
    logic full;
  } lmmt_qstat_t;

endpackage

// File: rtl/lmmt_front.sv
module lmmt_front (
  input  logic                 start,
  output logic                 busy,
  input  lmmt_pkg::lmmt_in_t   item_i,
  input  lmmt_pkg::lmmt_qstat_t qstat_i,
  output logic                 push_o,
  output lmmt_pkg::lmmt_cmd_t  cmd_o
);

  localparam int TW = lmmt_pkg::TIME_W;

  logic signed [TW+1:0] diff;
  logic signed [TW+1:0] adj;
  logic signed [TW+1:0] wrap_s;
  logic [TW-1:0]        elapsed;
  logic                 slot_ok;

  // The front takes an item whenever the queue has room.
  assign busy   = qstat_i.full;
  assign push_o = start && !qstat_i.full;

  // Elapsed time with the wrap correction, clamped into one wrap period.
  always_comb begin
    wrap_s = $signed({2'b00, lmmt_pkg::US_PER_WRAP});
    diff   = $signed({2'b00, item_i.now_us}) - $signed({2'b00, item_i.start_us});
    if (diff <= 0) begin
      adj = diff + wrap_s;
    end else begin
      adj = diff;
    end
    if (adj < 1) begin
      elapsed = TW'(1);
    end else if (adj > wrap_s) begin
      elapsed = lmmt_pkg::US_PER_WRAP;
    end else begin
      elapsed = adj[TW-1:0];
    end
  end

  // Items addressing a slot that does not exist change no state.
  assign slot_ok = int'(item_i.slot) < lmmt_pkg::SLOTS;

  always_comb begin
    cmd_o.kind       = slot_ok ? lmmt_pkg::CMD_UPDATE : lmmt_pkg::CMD_SKIP;
    cmd_o.slot       = item_i.slot;
    cmd_o.elapsed_us = elapsed;
  end

endmodule

// File: rtl/lmmt_queue.sv
module lmmt_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  lmmt_pkg::lmmt_cmd_t   cmd_i,
  input  logic                  pop_i,
  output lmmt_pkg::lmmt_cmd_t   head_o,
  output lmmt_pkg::lmmt_qstat_t qstat_o
);

  localparam int Depth = lmmt_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  lmmt_pkg::lmmt_cmd_t entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage carries payload only.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign head_o        = entry_q[rd_ptr_q];
  assign qstat_o.empty = (cnt_q == '0);
  assign qstat_o.full  = (cnt_q == CntW'(Depth));

endmodule

// File: rtl/lmmt_back.sv
module lmmt_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lmmt_pkg::lmmt_qstat_t qstat_i,
  input  lmmt_pkg::lmmt_cmd_t   head_i,
  output logic                  pop_o,
  output logic                  done_o,
  output lmmt_pkg::lmmt_out_t   result_o
);

  localparam int TW    = lmmt_pkg::TIME_W;
  localparam int CW    = lmmt_pkg::COUNT_W;
  localparam int IdxW  = lmmt_pkg::SLOT_IDX_W;
  localparam int ProdW = TW + CW;
  localparam int StepW = $clog2(TW);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_MUL,
    S_PREP,
    S_DIV,
    S_FIN
  } state_e;

  state_e state_q;

  // Per-slot statistics, cleared by reset.
  logic [TW-1:0] min_q   [lmmt_pkg::SLOTS];
  logic [TW-1:0] max_q   [lmmt_pkg::SLOTS];
  logic [TW-1:0] mean_q  [lmmt_pkg::SLOTS];
  logic [CW-1:0] count_q [lmmt_pkg::SLOTS];

  // Working registers of the item in flight.
  lmmt_pkg::lmmt_cmd_t cmd_q;
  logic [TW-1:0]    cur_mean_q;
  logic [CW-1:0]    cur_cnt_q;
  logic [TW-1:0]    new_min_q;
  logic [TW-1:0]    new_max_q;
  logic [CW-1:0]    new_cnt_q;
  logic [ProdW-1:0] prod_q;
  logic [CW-1:0]    rem_q;
  logic [TW-1:0]    quo_q;
  logic [CW:0]      dvs_q;
  logic [StepW-1:0] step_q;
  logic             done_q;
  lmmt_pkg::lmmt_out_t result_q;

  logic [IdxW-1:0]  idx;
  logic [TW-1:0]    rd_min;
  logic [TW-1:0]    rd_max;
  logic [TW-1:0]    rd_mean;
  logic [CW-1:0]    rd_cnt;
  logic [TW-1:0]    upd_min;
  logic [TW-1:0]    upd_max;
  logic [CW-1:0]    upd_cnt;
  logic [ProdW-1:0] prod_c;
  logic [ProdW:0]   num_c;
  logic [CW:0]      trial;
  logic [CW:0]      trial_sub;
  logic             q_bit;

  // Read the addressed slot and form the new extremes and count.
  always_comb begin
    idx     = IdxW'(cmd_q.slot);
    rd_min  = min_q[idx];
    rd_max  = max_q[idx];
    rd_mean = mean_q[idx];
    rd_cnt  = count_q[idx];
    upd_min = (rd_min == '0 || rd_min > cmd_q.elapsed_us) ? cmd_q.elapsed_us : rd_min;
    upd_max = (rd_max < cmd_q.elapsed_us) ? cmd_q.elapsed_us : rd_max;
    upd_cnt = (rd_cnt == lmmt_pkg::COUNT_MAX) ? rd_cnt : rd_cnt + CW'(1);
  end

  // Old mean times old count; the numerator never exceeds 1e6 * 2^32.
  assign prod_c = cur_mean_q * cur_cnt_q;
  assign num_c  = {1'b0, prod_q} + (ProdW + 1)'(cmd_q.elapsed_us);

  // One restoring division step; the quotient is known to fit the time width.
  always_comb begin
    trial     = {rem_q, quo_q[TW-1]};
    trial_sub = trial - dvs_q;
    q_bit     = (trial >= dvs_q);
  end

  assign pop_o = (state_q == S_IDLE) && !qstat_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      for (int i = 0; i < lmmt_pkg::SLOTS; i++) begin
        min_q[i]   <= '0;
        max_q[i]   <= '0;
        mean_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else begin
      done_q <= 1'b0;
      case (state_q)
        // Take the next queued item.
        S_IDLE: begin
          if (!qstat_i.empty) begin
            cmd_q   <= head_i;
            state_q <= S_LOAD;
          end
        end
        // Skips finish at once; others update extremes and count, first samples finishing at once.
        S_LOAD: begin
          if (cmd_q.kind == lmmt_pkg::CMD_SKIP) begin
            result_q <= '{elapsed_us: cmd_q.elapsed_us, default: '0};
            done_q   <= 1'b1;
            state_q  <= S_IDLE;
          end else if (rd_cnt == '0) begin
            min_q[idx]   <= upd_min;
            max_q[idx]   <= upd_max;
            mean_q[idx]  <= cmd_q.elapsed_us;
            count_q[idx] <= CW'(1);
            result_q     <= '{elapsed_us:   cmd_q.elapsed_us,
                              min_us:       upd_min,
                              max_us:       upd_max,
                              mean_us:      cmd_q.elapsed_us,
                              sample_count: CW'(1)};
            done_q       <= 1'b1;
            state_q      <= S_IDLE;
          end else begin
            min_q[idx]   <= upd_min;
            max_q[idx]   <= upd_max;
            count_q[idx] <= upd_cnt;
            new_min_q    <= upd_min;
            new_max_q    <= upd_max;
            new_cnt_q    <= upd_cnt;
            cur_mean_q   <= rd_mean;
            cur_cnt_q    <= rd_cnt;
            state_q      <= S_MUL;
          end
        end
        // Register the product before the add.
        S_MUL: begin
          prod_q  <= prod_c;
          state_q <= S_PREP;
        end
        // Load the divider: upper numerator bits seed the remainder.
        S_PREP: begin
          rem_q   <= num_c[ProdW-1:TW];
          quo_q   <= num_c[TW-1:0];
          dvs_q   <= {1'b0, cur_cnt_q} + (CW + 1)'(1);
          step_q  <= '0;
          state_q <= S_DIV;
        end
        // One quotient bit per cycle.
        S_DIV: begin
          rem_q <= q_bit ? trial_sub[CW-1:0] : trial[CW-1:0];
          quo_q <= {quo_q[TW-2:0], q_bit};
          if (step_q == StepW'(TW - 1)) begin
            state_q <= S_FIN;
          end else begin
            step_q <= step_q + StepW'(1);
          end
        end
        // Store the new mean and deliver the result.
        S_FIN: begin
          mean_q[idx] <= quo_q;
          result_q    <= '{elapsed_us:   cmd_q.elapsed_us,
                           min_us:       new_min_q,
                           max_us:       new_max_q,
                           mean_us:      quo_q,
                           sample_count: new_cnt_q};
          done_q      <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  // A slot has a sample exactly when its minimum is nonzero.
  a_min_vs_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ((result_q.sample_count == '0) == (result_q.min_us == '0)))
    else $error("min and sample count disagree");

  // The running mean stays between the extremes.
  a_mean_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && result_q.sample_count != '0) |->
      (result_q.min_us <= result_q.mean_us && result_q.mean_us <= result_q.max_us))
    else $error("mean outside min/max");

  // The divider never runs with a zero divisor.
  a_dvs_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (dvs_q != '0))
    else $error("zero divisor");

  // Result strobes never come back to back.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("back-to-back done strobes");

endmodule

// File: rtl/latency_min_max_mean_tracker.sv
// Latency tracker with per-slot minimum, maximum, truncated running mean and
// saturating sample count. An item is taken when start is high and busy is
// low; busy is high only while the two-entry queue in front of the update
// engine is full. Each item produces exactly one result, presented on
// result_o for a single cycle with done_o high; the receiver cannot stall it,
// so it must capture the result in that cycle. An item that updates a slot
// with earlier samples runs the multiply, divider-load, 20-step restoring
// divide and finish states of the mean update; a first sample or an item for
// a slot that does not exist finishes in the load state. The engine takes one
// item at a time while the queue holds up to two more. All statistics are
// cleared by reset at once, with no clearing pass.
module latency_min_max_mean_tracker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  lmmt_pkg::lmmt_in_t  item_i,
  output logic                done_o,
  output lmmt_pkg::lmmt_out_t result_o
);

  lmmt_pkg::lmmt_qstat_t qstat;
  lmmt_pkg::lmmt_cmd_t   push_cmd;
  lmmt_pkg::lmmt_cmd_t   head_cmd;
  logic                  push;
  logic                  pop;

  // Front end: elapsed time and slot classification.
  lmmt_front u_front (
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .qstat_i (qstat),
    .push_o  (push),
    .cmd_o   (push_cmd)
  );

  // Queue decoupling acceptance from the update engine.
  lmmt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .head_o  (head_cmd),
    .qstat_o (qstat)
  );

  // Back end: statistics store and mean update.
  lmmt_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .qstat_i  (qstat),
    .head_i   (head_cmd),
    .pop_o    (pop),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int          MAX_CYCLES  = 400000;
  localparam int          TAIL_CYCLES = 60;
  localparam int          PHASE_ITEMS = 434;
  localparam int          MAX_REPORTS = 10;
  localparam logic [19:0] WRAP        = lmmt_pkg::US_PER_WRAP;
  localparam longint      WRAP_L      = longint'(lmmt_pkg::US_PER_WRAP);

  // One row of the directed table: the item, and optionally its typed-in result.
  typedef struct packed {
    lmmt_pkg::lmmt_in_t  item;
    logic                typed;
    lmmt_pkg::lmmt_out_t want;
  } stim_row_t;

  localparam lmmt_pkg::lmmt_out_t NO_WANT  = '0;
  localparam int                  NUM_ROWS = 21;

  // Directed items: first samples, zero differences, wraps and out-of-range stamps.
  stim_row_t directed_rows [NUM_ROWS] = '{
    '{'{3'd0, 20'd100, 20'd350}, 1'b1, '{20'd250, 20'd250, 20'd250, 20'd250, 32'd1}},
    '{'{3'd0, 20'd500, 20'd500}, 1'b0, NO_WANT},
    '{'{3'd0, 20'd10, 20'd20}, 1'b0, NO_WANT},
    '{'{3'd1, 20'd999999, 20'd0}, 1'b1, '{20'd1, 20'd1, 20'd1, 20'd1, 32'd1}},
    '{'{3'd1, 20'd0, 20'd999999}, 1'b0, NO_WANT},
    '{'{3'd2, 20'd0, 20'd1048575}, 1'b1, '{WRAP, WRAP, WRAP, WRAP, 32'd1}},
    '{'{3'd2, 20'd0, 20'd1}, 1'b0, NO_WANT},
    '{'{3'd3, 20'd1048575, 20'd0}, 1'b1, '{20'd1, 20'd1, 20'd1, 20'd1, 32'd1}},
    '{'{3'd3, 20'd1048575, 20'd1048575}, 1'b0, NO_WANT},
    '{'{3'd4, 20'd1000000, 20'd999999}, 1'b1,
      '{20'd999999, 20'd999999, 20'd999999, 20'd999999, 32'd1}},
    '{'{3'd4, 20'd524288, 20'd524287}, 1'b0, NO_WANT},
    '{'{3'd5, 20'd0, 20'd1}, 1'b1, '{20'd1, 20'd1, 20'd1, 20'd1, 32'd1}},
    '{'{3'd5, 20'd0, 20'd2}, 1'b0, NO_WANT},
    '{'{3'd5, 20'd7, 20'd5}, 1'b0, NO_WANT},
    '{'{3'd6, 20'd200000, 20'd100000}, 1'b1,
      '{20'd900000, 20'd900000, 20'd900000, 20'd900000, 32'd1}},
    '{'{3'd6, 20'd5, 20'd6}, 1'b0, NO_WANT},
    '{'{3'd7, 20'd1048575, 20'd1048575}, 1'b1, '{WRAP, WRAP, WRAP, WRAP, 32'd1}},
    '{'{3'd7, 20'd3, 20'd3}, 1'b0, NO_WANT},
    '{'{3'd7, 20'd699050, 20'd349525}, 1'b0, NO_WANT},
    '{'{3'd0, 20'd349525, 20'd699050}, 1'b0, NO_WANT},
    '{'{3'd6, 20'd0, 20'd0}, 1'b0, NO_WANT}
  };

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                start  = 1'b0;
  logic                busy;
  lmmt_pkg::lmmt_in_t  item_i = '0;
  logic                done_o;
  lmmt_pkg::lmmt_out_t result_o;

  // Predicted per-slot statistics.
  logic [lmmt_pkg::TIME_W-1:0]  min_tbl   [lmmt_pkg::SLOTS];
  logic [lmmt_pkg::TIME_W-1:0]  max_tbl   [lmmt_pkg::SLOTS];
  logic [lmmt_pkg::TIME_W-1:0]  mean_tbl  [lmmt_pkg::SLOTS];
  logic [lmmt_pkg::COUNT_W-1:0] count_tbl [lmmt_pkg::SLOTS];

  lmmt_pkg::lmmt_out_t expected_stats_q [$];
  int                  mismatch_count = 0;
  int                  cycle_count    = 0;

  latency_min_max_mean_tracker dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Wrap-corrected elapsed time, then the slot update it causes.
  function automatic lmmt_pkg::lmmt_out_t predict_latency_stats(lmmt_pkg::lmmt_in_t it);
    longint                      diff;
    logic [lmmt_pkg::TIME_W-1:0] el;
    logic [63:0]                 cnt;
    logic [63:0]                 total;
    lmmt_pkg::lmmt_out_t         res;
    diff = longint'(it.now_us) - longint'(it.start_us);
    if (diff <= 0) begin
      diff += WRAP_L;
    end
    if (diff < 1) begin
      diff = 1;
    end
    if (diff > WRAP_L) begin
      diff = WRAP_L;
    end
    el = diff[lmmt_pkg::TIME_W-1:0];
    res = '0;
    res.elapsed_us = el;
    if (int'(it.slot) >= lmmt_pkg::SLOTS) begin
      return res;
    end
    if (min_tbl[it.slot] == '0 || min_tbl[it.slot] > el) begin
      min_tbl[it.slot] = el;
    end
    if (max_tbl[it.slot] < el) begin
      max_tbl[it.slot] = el;
    end
    if (count_tbl[it.slot] == '0) begin
      count_tbl[it.slot] = 1;
      mean_tbl[it.slot]  = el;
    end else begin
      // Full-width product; the divisor is count + 1 even when the count is saturated.
      cnt   = 64'(count_tbl[it.slot]);
      total = 64'(mean_tbl[it.slot]) * cnt + 64'(el);
      total = total / (cnt + 64'd1);
      mean_tbl[it.slot] = total[lmmt_pkg::TIME_W-1:0];
      if (count_tbl[it.slot] != lmmt_pkg::COUNT_MAX) begin
        count_tbl[it.slot] = count_tbl[it.slot] + 1;
      end
    end
    res.min_us       = min_tbl[it.slot];
    res.max_us       = max_tbl[it.slot];
    res.mean_us      = mean_tbl[it.slot];
    res.sample_count = count_tbl[it.slot];
    return res;
  endfunction

  // Random measurement, weighted toward short latencies, zero differences and wraps.
  function automatic lmmt_pkg::lmmt_in_t random_measurement();
    lmmt_pkg::lmmt_in_t it;
    int                 pick;
    int                 base;
    pick = $urandom_range(0, 99);
    base = $urandom_range(0, 999999);
    it.slot     = lmmt_pkg::SLOT_W'($urandom_range(0, lmmt_pkg::SLOTS - 1));
    it.start_us = lmmt_pkg::TIME_W'(base);
    if (pick < 50) begin
      it.now_us = lmmt_pkg::TIME_W'($urandom_range(0, 999999));
    end else if (pick < 72) begin
      it.now_us = lmmt_pkg::TIME_W'((base + $urandom_range(1, 2000)) % 1000000);
    end else if (pick < 82) begin
      it.now_us = lmmt_pkg::TIME_W'(base);
    end else if (pick < 94) begin
      // Stamps beyond the counter's range exercise the saturation of the difference.
      it.start_us = lmmt_pkg::TIME_W'($urandom());
      it.now_us   = lmmt_pkg::TIME_W'($urandom());
    end else begin
      it.now_us = lmmt_pkg::TIME_W'((base + 1) % 1000000);
    end
    return it;
  endfunction

  // Present one item after random idle cycles and record its expected result.
  task automatic send_item(input lmmt_pkg::lmmt_in_t it, input int idle_pct,
                           input logic typed, input lmmt_pkg::lmmt_out_t want);
    lmmt_pkg::lmmt_out_t predicted;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    predicted = predict_latency_stats(it);
    expected_stats_q.push_back(typed ? want : predicted);
  endtask

  // Hold off the sender until every outstanding result has come back.
  task automatic wait_for_results();
    start <= 1'b0;
    do @(posedge clk_i); while (expected_stats_q.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      end
    end
  endtask

  // Result checker: every strobe must match the oldest expectation.
  always @(posedge clk_i) begin
    lmmt_pkg::lmmt_out_t want;
    if (rst_ni && done_o) begin
      if (expected_stats_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("%0t: result with no item outstanding: elapsed %0d", $time,
                   result_o.elapsed_us);
        end
      end else begin
        want = expected_stats_q.pop_front();
        check_field("elapsed_us", 32'(want.elapsed_us), 32'(result_o.elapsed_us));
        check_field("min_us", 32'(want.min_us), 32'(result_o.min_us));
        check_field("max_us", 32'(want.max_us), 32'(result_o.max_us));
        check_field("mean_us", 32'(want.mean_us), 32'(result_o.mean_us));
        check_field("sample_count", want.sample_count, result_o.sample_count);
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stimulus: directed table, then three random phases with different sender idling.
  initial begin
    for (int s = 0; s < lmmt_pkg::SLOTS; s++) begin
      min_tbl[s]   = '0;
      max_tbl[s]   = '0;
      mean_tbl[s]  = '0;
      count_tbl[s] = '0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    for (int r = 0; r < NUM_ROWS; r++) begin
      send_item(directed_rows[r].item, 34, directed_rows[r].typed, directed_rows[r].want);
    end
    wait_for_results();

    for (int n = 0; n < PHASE_ITEMS; n++) begin
      send_item(random_measurement(), 34, 1'b0, NO_WANT);
    end
    wait_for_results();

    for (int n = 0; n < PHASE_ITEMS; n++) begin
      send_item(random_measurement(), 61, 1'b0, NO_WANT);
    end
    wait_for_results();

    for (int n = 0; n < PHASE_ITEMS; n++) begin
      send_item(random_measurement(), 0, 1'b0, NO_WANT);
    end
    wait_for_results();

    // Let any stray strobe show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_stats_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
